// ===== hw/rtl/gpf_pkg.sv =====
`default_nettype none
package gpf_pkg;
    localparam int MAX_FACTORS_DEF = 32;
    localparam int VALUE_BITS_DEF  = 31;
    localparam int COUNT_BITS      = 6;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 6'd63;

    typedef struct packed {
        logic start;
        logic done;
    } lane_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/gcd_by_prime_factor_merge_core.sv =====
`default_nettype none
// Channel | Ports                                           | Dir
// input   | s_valid s_ready s_first_value s_second_value    | in
// result  | m_valid m_ready m_gcd_result m_factor_count     | out
// Two lanes factor the operands in parallel; each odd trial divisor costs one
// restoring division (lane states S_DIV, S_WAIT); the merge then walks both
// factor lists once both lanes are done.
// Reset is synchronous, active low; no clearing pass.
// The result register frees the core, so a new beat is taken while one waits;
// the merge of that beat holds until the result register is empty.
module gcd_by_prime_factor_merge_core #(
    parameter int VALUE_BITS  = gpf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = gpf_pkg::MAX_FACTORS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [VALUE_BITS-1:0]          s_first_value,
    input  wire logic [VALUE_BITS-1:0]          s_second_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [VALUE_BITS-1:0]          m_gcd_result,
    output logic      [gpf_pkg::COUNT_BITS-1:0] m_factor_count
);
    import gpf_pkg::*;

    localparam int AW = $clog2(MAX_FACTORS);
    localparam int LW = $clog2(MAX_FACTORS + 1);

    logic                  busy_reg, busy_next;
    logic                  da_reg, db_reg;
    logic                  mv_reg;
    logic                  mrun_reg;
    logic [VALUE_BITS-1:0] res_g_reg;
    logic [COUNT_BITS-1:0] res_c_reg;
    logic                  take;
    logic                  done_a, done_b;
    logic                  both_done;
    logic                  fin_ok;
    logic [AW-1:0]         ra, rb;
    logic [VALUE_BITS-1:0] xa, xb;
    logic [LW-1:0]         la, lb;
    logic [COUNT_BITS-1:0] fa, fb;
    logic [COUNT_BITS:0]   tot;
    lane_ctl_t             mctl_in, mctl_out;
    logic [VALUE_BITS-1:0] g;

    assign s_ready = !busy_reg;
    assign take    = s_valid && s_ready;

    gpf_lane #(.VALUE_BITS(VALUE_BITS), .MAX_FACTORS(MAX_FACTORS)) u_lane_a (
        .aclk(aclk), .aresetn(aresetn), .start(take), .value(s_first_value),
        .raddr(ra), .rdata(xa), .list_len(la), .found(fa), .done(done_a)
    );
    gpf_lane #(.VALUE_BITS(VALUE_BITS), .MAX_FACTORS(MAX_FACTORS)) u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .start(take), .value(s_second_value),
        .raddr(rb), .rdata(xb), .list_len(lb), .found(fb), .done(done_b)
    );

    // hold the merge while the previous result still waits
    assign both_done     = (da_reg || done_a) && (db_reg || done_b);
    assign mctl_in.start = both_done && busy_reg && !mctl_out.done && !mrun_reg && !mv_reg;
    assign mctl_in.done  = 1'b0;

    gpf_merge #(.VALUE_BITS(VALUE_BITS), .MAX_FACTORS(MAX_FACTORS)) u_merge (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(mctl_in), .len_a(la), .len_b(lb),
        .x(xa), .y(xb), .raddr_a(ra), .raddr_b(rb), .gcd(g), .ctl_out(mctl_out)
    );

    assign tot = {1'b0, fa} + {1'b0, fb};

    assign fin_ok    = mctl_out.done;
    assign busy_next = take ? 1'b1 : (fin_ok ? 1'b0 : busy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            da_reg   <= 1'b0;
            db_reg   <= 1'b0;
            mrun_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (take) begin
                da_reg <= 1'b0;
                db_reg <= 1'b0;
            end else begin
                if (done_a) da_reg <= 1'b1;
                if (done_b) db_reg <= 1'b1;
            end
            if (mctl_in.start)     mrun_reg <= 1'b1;
            else if (fin_ok)       mrun_reg <= 1'b0;
            if (fin_ok)            mv_reg <= 1'b1;
            else if (m_ready)      mv_reg <= 1'b0;
        end
        if (fin_ok) begin
            res_g_reg <= g;
            res_c_reg <= tot[COUNT_BITS] ? COUNT_MAX : tot[COUNT_BITS-1:0];
        end
    end

    assign m_valid        = mv_reg;
    assign m_gcd_result   = res_g_reg;
    assign m_factor_count = res_c_reg;

    ap_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_ok |-> !mv_reg || m_ready) else $error("result overwritten");
    ap_busy_take: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> busy_reg) else $error("busy not set");
    ap_one_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        mctl_in.start |-> !mrun_reg) else $error("merge restarted");
endmodule
`default_nettype wire

// ===== hw/rtl/gpf_ram.sv =====
`default_nettype none
module gpf_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gpf_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gpf_divider #(
    parameter int W = 31
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, quo_reg[W-1]};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next    = W'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/gpf_lane.sv =====
`default_nettype none
// One factoring lane: trial division of one operand, factors written to a RAM.
module gpf_lane #(
    parameter int VALUE_BITS  = gpf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = gpf_pkg::MAX_FACTORS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [VALUE_BITS-1:0]               value,
    input  wire logic [$clog2(MAX_FACTORS)-1:0]      raddr,
    output logic      [VALUE_BITS-1:0]               rdata,
    output logic      [$clog2(MAX_FACTORS+1)-1:0]    list_len,
    output logic      [gpf_pkg::COUNT_BITS-1:0]      found,
    output logic                                     done
);
    import gpf_pkg::*;

    localparam int AW = $clog2(MAX_FACTORS);
    localparam int LW = $clog2(MAX_FACTORS + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_TWO = 3'd1, S_DIV = 3'd2,
                           S_WAIT = 3'd3, S_LAST = 3'd4;

    logic [2:0]            st_reg, st_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [COUNT_BITS-1:0] fnd_reg, fnd_next;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_q, div_r;
    logic                  we;
    logic [VALUE_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] fnd_inc;

    gpf_divider #(.W(VALUE_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(n_reg), .divisor(d_reg),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    gpf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_FACTORS)) u_ram (
        .aclk(aclk), .we(we), .waddr(len_reg[AW-1:0]), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign fnd_inc = (fnd_reg == COUNT_MAX) ? fnd_reg : fnd_reg + 1'b1;

    always_comb begin
        st_next   = st_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        len_next  = len_reg;
        fnd_next  = fnd_reg;
        div_start = 1'b0;
        we        = 1'b0;
        wdata     = d_reg;
        done      = 1'b0;
        case (st_reg)
            S_IDLE: begin
                if (start) begin
                    n_next   = value;
                    d_next   = VALUE_BITS'(3);
                    len_next = '0;
                    fnd_next = '0;
                    st_next  = (value < VALUE_BITS'(2)) ? S_LAST : S_TWO;
                end
            end
            S_TWO: begin
                if (!n_reg[0]) begin
                    wdata    = VALUE_BITS'(2);
                    we       = (len_reg < LW'(MAX_FACTORS));
                    len_next = we ? len_reg + 1'b1 : len_reg;
                    fnd_next = fnd_inc;
                    n_next   = n_reg >> 1;
                end else begin
                    div_start = 1'b1;
                    st_next   = S_WAIT;
                end
            end
            S_DIV: begin
                div_start = 1'b1;
                st_next   = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    // loop ends once d exceeds n / d
                    if (d_reg > div_q) begin
                        st_next = S_LAST;
                    end else if (div_r == '0) begin
                        we       = (len_reg < LW'(MAX_FACTORS));
                        len_next = we ? len_reg + 1'b1 : len_reg;
                        fnd_next = fnd_inc;
                        n_next   = div_q;
                        st_next  = S_DIV;
                    end else begin
                        d_next  = d_reg + VALUE_BITS'(2);
                        st_next = S_DIV;
                    end
                end
            end
            S_LAST: begin
                if (n_reg > VALUE_BITS'(1)) begin
                    wdata    = n_reg;
                    we       = (len_reg < LW'(MAX_FACTORS));
                    len_next = we ? len_reg + 1'b1 : len_reg;
                    fnd_next = fnd_inc;
                end
                done    = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            len_reg <= '0;
            fnd_reg <= '0;
        end else begin
            st_reg  <= st_next;
            len_reg <= len_next;
            fnd_reg <= fnd_next;
        end
        n_reg <= n_next;
        d_reg <= d_next;
    end

    assign list_len = len_reg;
    assign found    = fnd_reg;

    ap_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_FACTORS)) else $error("list length overflow");
    ap_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> st_reg == S_WAIT) else $error("divider done outside wait");
    ap_odd_div: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == S_WAIT |-> d_reg[0]) else $error("even trial divisor");
endmodule
`default_nettype wire

// ===== hw/rtl/gpf_merge.sv =====
`default_nettype none
// Walks both sorted lists, multiplying common factors.
module gpf_merge #(
    parameter int VALUE_BITS  = gpf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = gpf_pkg::MAX_FACTORS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire gpf_pkg::lane_ctl_t               ctl_in,
    input  wire logic [$clog2(MAX_FACTORS+1)-1:0] len_a,
    input  wire logic [$clog2(MAX_FACTORS+1)-1:0] len_b,
    input  wire logic [VALUE_BITS-1:0]            x,
    input  wire logic [VALUE_BITS-1:0]            y,
    output logic      [$clog2(MAX_FACTORS)-1:0]   raddr_a,
    output logic      [$clog2(MAX_FACTORS)-1:0]   raddr_b,
    output logic      [VALUE_BITS-1:0]            gcd,
    output gpf_pkg::lane_ctl_t                    ctl_out
);
    import gpf_pkg::*;

    localparam int LW = $clog2(MAX_FACTORS + 1);
    localparam int AW = $clog2(MAX_FACTORS);
    localparam logic [1:0] M_IDLE = 2'd0, M_READ = 2'd1, M_CMP = 2'd2, M_MUL = 2'd3;

    logic [1:0]              st_reg, st_next;
    logic [LW-1:0]           i_reg, i_next, j_reg, j_next;
    logic [VALUE_BITS-1:0]   g_reg, g_next;
    logic [VALUE_BITS-1:0]   f_reg, f_next;
    logic [2*VALUE_BITS-1:0] prod;
    logic                    fin;

    assign raddr_a = i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];
    assign prod    = g_reg * f_reg;

    always_comb begin
        st_next = st_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        g_next  = g_reg;
        f_next  = f_reg;
        fin     = 1'b0;
        case (st_reg)
            M_IDLE: begin
                if (ctl_in.start) begin
                    i_next  = '0;
                    j_next  = '0;
                    g_next  = VALUE_BITS'(1);
                    st_next = M_READ;
                end
            end
            M_READ: begin
                if (i_reg >= len_a || j_reg >= len_b) begin
                    fin     = 1'b1;
                    st_next = M_IDLE;
                end else begin
                    st_next = M_CMP;
                end
            end
            M_CMP: begin
                if (x == y) begin
                    f_next  = x;
                    i_next  = i_reg + 1'b1;
                    j_next  = j_reg + 1'b1;
                    st_next = M_MUL;
                end else begin
                    if (x < y) i_next = i_reg + 1'b1;
                    else       j_next = j_reg + 1'b1;
                    st_next = M_READ;
                end
            end
            M_MUL: begin
                g_next  = prod[VALUE_BITS-1:0];
                st_next = M_READ;
            end
            default: st_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= M_IDLE;
        end else begin
            st_reg <= st_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        g_reg <= g_next;
        f_reg <= f_next;
    end

    assign gcd           = g_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = fin;

    ap_fin_read: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |-> st_reg == M_READ) else $error("merge finish outside read");
endmodule
`default_nettype wire
